/* design/assert_macros.svh */
// assertion macros used by the event builder rtl
// no dependencies; assertions compile out under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CEB_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define CEB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CEB_ASSERT(lbl, clk, rst_n, expr)

`define CEB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define CEB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/ceb_pkg.sv */
// types, widths and codes of the coincidence event builder
// no dependencies
package ceb_pkg;

    localparam int TIME_W   = 48;
    localparam int ENERGY_W = 24;
    localparam int SUM_W    = 32;
    localparam int DET_W    = 8;
    localparam int EVID_W   = 32;
    localparam int HITID_W  = 16;
    localparam int MULT_W   = 16;
    localparam int WIN_W    = 24;
    localparam int SRC_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // record kinds
    localparam logic KIND_MEMBER  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_SOURCE = 1'b1;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(20000);
    localparam logic [MULT_W-1:0] MULT_MAX     = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX      = '1;

    typedef struct packed {
        logic                req_type;
        logic [TIME_W-1:0]   sample_time;
        logic [ENERGY_W-1:0] sample_energy;
        logic [DET_W-1:0]    detector_id;
        logic [EVID_W-1:0]   event_id;
        logic [HITID_W-1:0]  hit_id;
        logic                end_of_hit;
    } t_sample;

    typedef struct packed {
        logic               record_kind;
        logic [EVID_W-1:0]  out_event_id;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [MULT_W-1:0]  multiplicity;
        logic [SUM_W-1:0]   hit_energy;
        logic [DET_W-1:0]   out_detector;
        logic [HITID_W-1:0] out_hit_id;
        logic [SRC_W-1:0]   out_source;
        logic               last_result;
    } t_record;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [SRC_W-1:0] source;
    } t_cfg;

    // records produced by one item, first goes out first
    typedef struct packed {
        logic    first_valid;
        t_record first;
        logic    second_valid;
        t_record second;
    } t_push;

endpackage

/* design/ceb_ifs.sv */
// valid/ready channel interfaces for samples and records
// depends on ceb_pkg
interface ceb_sample_if;
    logic              valid;
    logic              ready;
    ceb_pkg::t_sample  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ceb_record_if;
    logic              valid;
    logic              ready;
    ceb_pkg::t_record  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/coincidence_event_builder_unit.sv */
// coincidence window event builder: an item goes to an input register, the hit and event
// logic works on it combinationally and writes its records into a four-entry output queue
// an item waits in the input register while the queue lacks room; throughput: one item per
// cycle while items give at most one record and the queue has room; an item closing an
// event gives two records, which leave one at a time through the queue's single read port
// reset: synchronous active low, clears hit and event state and queue, restores the registers
module coincidence_event_builder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ceb_sample_if.sink                  i_sample,
    ceb_record_if.source                o_record,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ceb_pkg::ADDR_W-1:0]  paddr,
    input  logic [ceb_pkg::DATA_W-1:0]  pwdata,
    output logic [ceb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ceb_pkg::t_cfg  cfg;
    ceb_pkg::t_push push;
    logic           room;

    ceb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ceb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (cfg),
        .i_room   (room),
        .o_push   (push)
    );

    ceb_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_record (o_record)
    );

endmodule

/* design/ceb_apb_regs.sv */
// apb configuration registers: coincidence window and source number
// depends on ceb_pkg
module ceb_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ceb_pkg::ADDR_W-1:0]  paddr,
    input  logic [ceb_pkg::DATA_W-1:0]  pwdata,
    output logic [ceb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ceb_pkg::t_cfg               o_cfg
);

    logic [ceb_pkg::WIN_W-1:0] r_window;
    logic [ceb_pkg::SRC_W-1:0] r_source;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= ceb_pkg::WINDOW_RESET;
            r_source <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                ceb_pkg::REG_WINDOW: r_window <= pwdata[ceb_pkg::WIN_W-1:0];
                ceb_pkg::REG_SOURCE: r_source <= pwdata[ceb_pkg::SRC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ceb_pkg::REG_WINDOW: prdata = ceb_pkg::DATA_W'(r_window);
            ceb_pkg::REG_SOURCE: prdata = ceb_pkg::DATA_W'(r_source);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.window = r_window;
    assign o_cfg.source = r_source;

endmodule

/* design/ceb_core.sv */
// input register, hit accumulation and event window decision
// depends on ceb_pkg and ceb_ifs
module ceb_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ceb_sample_if.sink        i_sample,
    input  ceb_pkg::t_cfg     i_cfg,
    input  logic              i_room,
    output ceb_pkg::t_push    o_push
);

    logic                         r_in_valid;
    ceb_pkg::t_sample             r_in;
    logic                         fire;

    logic                         r_hit_open, n_hit_open;
    logic [ceb_pkg::TIME_W-1:0]   r_hit_earliest, n_hit_earliest;
    logic [ceb_pkg::TIME_W-1:0]   r_hit_latest, n_hit_latest;
    logic [ceb_pkg::SUM_W-1:0]    r_hit_energy, n_hit_energy;
    logic                         r_event_open, n_event_open;
    logic [ceb_pkg::TIME_W-1:0]   r_event_start, n_event_start;
    logic [ceb_pkg::TIME_W-1:0]   r_event_end, n_event_end;
    logic [ceb_pkg::EVID_W-1:0]   r_event_number, n_event_number;
    logic [ceb_pkg::MULT_W-1:0]   r_event_hits, n_event_hits;

    logic [ceb_pkg::TIME_W-1:0]   hit_earliest;
    logic [ceb_pkg::TIME_W-1:0]   hit_latest;
    logic [ceb_pkg::SUM_W-1:0]    hit_energy;
    logic [ceb_pkg::SUM_W:0]      energy_add;
    logic [ceb_pkg::TIME_W:0]     limit;
    logic                         split;
    ceb_pkg::t_record             summary;
    ceb_pkg::t_record             member;

    assign fire           = r_in_valid & i_room;
    assign i_sample.ready = ~r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid & i_sample.ready) begin
            r_in <= i_sample.data;
        end
    end

    // hit running values including the sample in the input register
    always_comb begin
        energy_add = {1'b0, r_hit_energy} + (ceb_pkg::SUM_W + 1)'(r_in.sample_energy);
        if (!r_hit_open) begin
            hit_earliest = r_in.sample_time;
            hit_latest   = r_in.sample_time;
            hit_energy   = ceb_pkg::SUM_W'(r_in.sample_energy);
        end else begin
            hit_earliest = (r_in.sample_time < r_hit_earliest) ? r_in.sample_time
                                                               : r_hit_earliest;
            hit_latest   = (r_in.sample_time > r_hit_latest) ? r_in.sample_time
                                                             : r_hit_latest;
            hit_energy   = energy_add[ceb_pkg::SUM_W] ? ceb_pkg::SUM_MAX
                                                      : energy_add[ceb_pkg::SUM_W-1:0];
        end
        limit = {1'b0, r_event_end} + (ceb_pkg::TIME_W + 1)'(i_cfg.window);
        split = r_event_open && (({1'b0, hit_earliest} > limit) ||
                                 (r_in.event_id != r_event_number));
    end

    always_comb begin
        summary.record_kind  = ceb_pkg::KIND_SUMMARY;
        summary.out_event_id = r_event_number;
        summary.start_time   = r_event_start;
        summary.end_time     = r_event_end;
        summary.multiplicity = r_event_hits;
        summary.hit_energy   = '0;
        summary.out_detector = '0;
        summary.out_hit_id   = '0;
        summary.out_source   = i_cfg.source;
        summary.last_result  = (r_in.req_type == ceb_pkg::REQ_FLUSH);

        member.record_kind   = ceb_pkg::KIND_MEMBER;
        member.out_event_id  = r_in.event_id;
        member.start_time    = hit_earliest;
        member.end_time      = hit_latest;
        member.multiplicity  = '0;
        member.hit_energy    = hit_energy;
        member.out_detector  = r_in.detector_id;
        member.out_hit_id    = r_in.hit_id;
        member.out_source    = i_cfg.source;
        member.last_result   = 1'b1;
    end

    always_comb begin
        n_hit_open     = r_hit_open;
        n_hit_earliest = r_hit_earliest;
        n_hit_latest   = r_hit_latest;
        n_hit_energy   = r_hit_energy;
        n_event_open   = r_event_open;
        n_event_start  = r_event_start;
        n_event_end    = r_event_end;
        n_event_number = r_event_number;
        n_event_hits   = r_event_hits;
        o_push         = '0;

        if (fire) begin
            if (r_in.req_type == ceb_pkg::REQ_FLUSH) begin
                if (r_event_open) begin
                    o_push.first_valid = 1'b1;
                    o_push.first       = summary;
                    n_event_open       = 1'b0;
                end
            end else begin
                n_hit_open     = ~r_in.end_of_hit;
                n_hit_earliest = hit_earliest;
                n_hit_latest   = hit_latest;
                n_hit_energy   = hit_energy;
                if (r_in.end_of_hit) begin
                    n_event_open = 1'b1;
                    if (split || !r_event_open) begin
                        n_event_start  = hit_earliest;
                        n_event_end    = hit_latest;
                        n_event_number = r_in.event_id;
                        n_event_hits   = ceb_pkg::MULT_W'(1);
                    end else begin
                        if (hit_latest > r_event_end) begin
                            n_event_end = hit_latest;
                        end
                        if (hit_earliest < r_event_start) begin
                            n_event_start = hit_earliest;
                        end
                        if (r_event_hits != ceb_pkg::MULT_MAX) begin
                            n_event_hits = r_event_hits + 1'b1;
                        end
                    end
                    if (split) begin
                        o_push.first_valid  = 1'b1;
                        o_push.first        = summary;
                        o_push.second_valid = 1'b1;
                        o_push.second       = member;
                    end else begin
                        o_push.first_valid  = 1'b1;
                        o_push.first        = member;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_open     <= 1'b0;
            r_hit_earliest <= '0;
            r_hit_latest   <= '0;
            r_hit_energy   <= '0;
            r_event_open   <= 1'b0;
            r_event_start  <= '0;
            r_event_end    <= '0;
            r_event_number <= '0;
            r_event_hits   <= '0;
        end else begin
            r_hit_open     <= n_hit_open;
            r_hit_earliest <= n_hit_earliest;
            r_hit_latest   <= n_hit_latest;
            r_hit_energy   <= n_hit_energy;
            r_event_open   <= n_event_open;
            r_event_start  <= n_event_start;
            r_event_end    <= n_event_end;
            r_event_number <= n_event_number;
            r_event_hits   <= n_event_hits;
        end
    end

endmodule

/* design/ceb_out_queue.sv */
// four-entry record queue taking up to two records per cycle
// depends on ceb_pkg, ceb_ifs and assert_macros.svh
`include "assert_macros.svh"

module ceb_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ceb_pkg::t_push    i_push,
    output logic              o_room,
    ceb_record_if.source      o_record
);

    ceb_pkg::t_record              r_mem [ceb_pkg::QDEPTH];
    logic [ceb_pkg::QAW-1:0]       r_wr;
    logic [ceb_pkg::QAW-1:0]       r_rd;
    logic [ceb_pkg::QAW:0]         r_count;
    logic                          pop;
    logic [1:0]                    npush;
    logic [ceb_pkg::QAW:0]         level;

    assign o_record.valid = (r_count != '0);
    assign o_record.data  = r_mem[r_rd];
    assign pop            = o_record.valid & o_record.ready;
    assign npush          = {1'b0, i_push.first_valid} + {1'b0, i_push.second_valid};

    // room for two records once this cycle's pop is counted
    assign level  = r_count - (ceb_pkg::QAW + 1)'(pop);
    assign o_room = (level <= (ceb_pkg::QAW + 1)'(ceb_pkg::QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[ceb_pkg::QAW'(r_wr + 1'b1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= ceb_pkg::QAW'(r_wr + npush);
            r_rd    <= ceb_pkg::QAW'(r_rd + pop);
            r_count <= level + (ceb_pkg::QAW + 1)'(npush);
        end
    end

    `CEB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (ceb_pkg::QAW + 1)'(ceb_pkg::QDEPTH))
    `CEB_ASSERT_IMPL(a_push_order, i_clk, i_rst_n, i_push.second_valid, i_push.first_valid)
    `CEB_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, i_push.first_valid, o_room)
    `CEB_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && (npush == 2'd0), r_count == $past(r_count) - 1'b1)

endmodule
